// ===== design/ssm_pkg.sv =====
// Shared types and codes for the sorted set merge block.
package ssm_pkg;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_ISECT  = 2'd2;
    localparam logic [1:0] MODE_DIFF   = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic [15:0] element;
        logic        last;
        logic        empty_res;
        logic        overflow;
    } t_res;

endpackage

// ===== design/ssm_list.sv =====
// Single list store: one write port, one read port with registered read data.
module ssm_list #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sorted_set_merge_ops.sv =====
// Top level: list loading and the two-pointer merge sequencer.
//
// Usage:
//   One command channel: a transaction is taken at a clock edge with start
//   high and busy low. Modes 0 and 1 append i_cmd.value to list A or B;
//   busy stays low, so loads may follow back to back. A load into
//   a full list is dropped and sets a sticky overflow flag.
//   Modes 2 and 3 run intersection or difference. busy rises for the run.
//   Each merge step is a list read, then a compare and advance, as the
//   single read port of each list has registered read data.
//   Results leave on o_res with o_res_valid high for exactly one cycle each,
//   in list A order, last marked; an empty result gives one item with
//   empty_res set. The receiver cannot stall; every strobe is a transaction.
//   After a run both lists and the overflow flag are cleared.
//   Reset (synchronous, active low) empties both lists, clears the flag and
//   returns the sequencer to idle.
module sorted_set_merge_ops #(
    parameter int LIST_DEPTH  = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  ssm_pkg::t_cmd i_cmd,
    output logic         busy,
    output logic         o_res_valid,
    output ssm_pkg::t_res o_res
);

    import ssm_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int SW = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ia, n_ia;
    logic [CW-1:0] r_ib, n_ib;
    logic          r_drop, n_drop;
    logic          r_diff, n_diff;
    logic          r_ovf, n_ovf;
    logic          r_pend_vld, n_pend_vld;
    logic [SW-1:0] r_pend, n_pend;
    logic          r_out_vld, n_out_vld;
    t_res          r_out, n_out;

    logic          accept;
    logic          we_a, we_b;
    logic [SW-1:0] wdata;
    logic [SW-1:0] rd_a, rd_b;
    logic          found;

    assign accept = start && (r_state == S_IDLE);
    assign wdata  = i_cmd.value[SW-1:0];

    ssm_list #(.DEPTH(LIST_DEPTH), .WIDTH(SW)) u_list_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_ia[AW-1:0]),
        .o_rdata (rd_a)
    );

    ssm_list #(.DEPTH(LIST_DEPTH), .WIDTH(SW)) u_list_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_ib[AW-1:0]),
        .o_rdata (rd_b)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_ia       = r_ia;
        n_ib       = r_ib;
        n_drop     = r_drop;
        n_diff     = r_diff;
        n_ovf      = r_ovf;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        we_a       = 1'b0;
        we_b       = 1'b0;
        found      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.mode)
                        MODE_LOAD_A: begin
                            if (r_cnt_a < DEPTH_C) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        MODE_LOAD_B: begin
                            if (r_cnt_b < DEPTH_C) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        MODE_ISECT, MODE_DIFF: begin
                            n_diff     = (i_cmd.mode == MODE_DIFF);
                            n_ovf      = r_drop;
                            n_ia       = '0;
                            n_ib       = '0;
                            n_pend_vld = 1'b0;
                            n_state    = S_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                if ((r_ia < r_cnt_a) && ((r_ib < r_cnt_b) || r_diff)) begin
                    n_state = S_CMP;
                end else begin
                    n_out_vld       = 1'b1;
                    n_out.last      = 1'b1;
                    n_out.overflow  = r_ovf;
                    n_out.empty_res = !r_pend_vld;
                    n_out.element   = r_pend_vld ? 16'(r_pend) : 16'd0;
                    n_cnt_a         = '0;
                    n_cnt_b         = '0;
                    n_drop          = 1'b0;
                    n_pend_vld      = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            S_CMP: begin
                if (r_ib < r_cnt_b) begin
                    if (rd_a < rd_b) begin
                        found = r_diff;
                        n_ia  = r_ia + 1'b1;
                    end else if (rd_a > rd_b) begin
                        n_ib = r_ib + 1'b1;
                    end else begin
                        found = !r_diff;
                        n_ia  = r_ia + 1'b1;
                        n_ib  = r_ib + 1'b1;
                    end
                end else begin
                    found = 1'b1;
                    n_ia  = r_ia + 1'b1;
                end
                if (found) begin
                    n_out_vld       = r_pend_vld;
                    n_out.element   = 16'(r_pend);
                    n_out.last      = 1'b0;
                    n_out.empty_res = 1'b0;
                    n_out.overflow  = r_ovf;
                    n_pend          = rd_a;
                    n_pend_vld      = 1'b1;
                end
                n_state = S_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_drop     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_drop     <= n_drop;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ia   <= n_ia;
        r_ib   <= n_ib;
        r_diff <= n_diff;
        r_ovf  <= n_ovf;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for sorted_set_merge_ops: directed and random list loads and runs.
module tb_top;
    import ssm_pkg::*;

    localparam int DEPTH       = 32;
    localparam int TOTAL_ITEMS = 330;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 4 * DEPTH + 20;

    class set_merge_scoreboard;
        logic [15:0] a_list[DEPTH];
        logic [15:0] b_list[DEPTH];
        int          a_cnt;
        int          b_cnt;
        bit          dropped;
        t_res        expected_results[$];
        int          mismatches;

        function new();
            a_cnt      = 0;
            b_cnt      = 0;
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void predict_merge(bit diff);
            logic [15:0] found[$];
            int          ia;
            int          ib;
            t_res        r;
            ia = 0;
            ib = 0;
            while (ia < a_cnt && ib < b_cnt) begin
                if (a_list[ia] < b_list[ib]) begin
                    if (diff) found.push_back(a_list[ia]);
                    ia++;
                end else if (a_list[ia] > b_list[ib]) begin
                    ib++;
                end else begin
                    if (!diff) found.push_back(a_list[ia]);
                    ia++;
                    ib++;
                end
            end
            if (diff) begin
                while (ia < a_cnt) begin
                    found.push_back(a_list[ia]);
                    ia++;
                end
            end
            if (found.size() == 0) begin
                r.element   = '0;
                r.last      = 1'b1;
                r.empty_res = 1'b1;
                r.overflow  = dropped;
                expected_results.push_back(r);
            end else begin
                foreach (found[k]) begin
                    r.element   = found[k];
                    r.last      = (k == found.size() - 1);
                    r.empty_res = 1'b0;
                    r.overflow  = dropped;
                    expected_results.push_back(r);
                end
            end
            a_cnt   = 0;
            b_cnt   = 0;
            dropped = 1'b0;
        endfunction

        function void note_cmd(t_cmd c);
            case (c.mode)
                MODE_LOAD_A: begin
                    if (a_cnt < DEPTH) begin
                        a_list[a_cnt] = c.value;
                        a_cnt++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                MODE_LOAD_B: begin
                    if (b_cnt < DEPTH) begin
                        b_list[b_cnt] = c.value;
                        b_cnt++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                MODE_ISECT: predict_merge(1'b0);
                default: predict_merge(1'b1);
            endcase
        endfunction

        function void check_res(t_res got);
            t_res want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result element=%0d last=%0b empty=%0b ovf=%0b",
                                          got.element, got.last, got.empty_res, got.overflow));
                return;
            end
            want = expected_results.pop_front();
            if (got.element !== want.element || got.last !== want.last ||
                got.empty_res !== want.empty_res || got.overflow !== want.overflow) begin
                report_mismatch($sformatf(
                    "expected element=%0d last=%0b empty=%0b ovf=%0b, got %0d %0b %0b %0b",
                    want.element, want.last, want.empty_res, want.overflow,
                    got.element, got.last, got.empty_res, got.overflow));
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_res_valid;
    t_cmd i_cmd;
    t_res o_res;
    int   cycle_count = 0;
    int   n_items;

    set_merge_scoreboard sb;

    sorted_set_merge_ops #(
        .LIST_DEPTH (DEPTH),
        .VALUE_WIDTH(16)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .busy       (busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) sb.check_res(o_res);
    end

    function automatic t_cmd mk_cmd(logic [1:0] m, logic [15:0] v);
        t_cmd c;
        c.mode  = m;
        c.value = v;
        return c;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic idle_cycles(int n);
        t_cmd noise;
        repeat (n) begin
            noise.mode  = 2'($urandom);
            noise.value = 16'($urandom);
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= noise;
        end
    endtask

    task automatic send_cmd(t_cmd c);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_cmd(c);
        n_items++;
    endtask

    task automatic issue(t_cmd c, bit gappy);
        if (gappy) idle_cycles(pick_gap());
        send_cmd(c);
    endtask

    // Drop start before waiting so the last transaction is not taken twice.
    task automatic drain_results();
        idle_cycles(1);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Build ascending A and B from one shared pool so that runs hit common elements.
    task automatic run_random_set(bit gappy);
        logic [15:0] a_vals[$];
        logic [15:0] b_vals[$];
        logic [16:0] v;
        int          pool_size;
        int          roll;
        int          step;
        int          pick;
        roll = $urandom_range(0, 99);
        if (roll < 65) pool_size = $urandom_range(0, 10);
        else if (roll < 88) pool_size = $urandom_range(11, 26);
        else pool_size = $urandom_range(27, 48);
        step = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 4000);
        v = (step > 4) ? 17'($urandom_range(0, 8000)) : 17'($urandom_range(0, 65535));
        for (int k = 0; k < pool_size; k++) begin
            pick = $urandom_range(0, 2);
            if (pick != 1) a_vals.push_back(v[15:0]);
            if (pick != 0) b_vals.push_back(v[15:0]);
            v = v + 17'($urandom_range(0, step));
            if (v > 17'd65535) v = 17'd65535;
        end
        while (a_vals.size() != 0 || b_vals.size() != 0) begin
            if (b_vals.size() == 0 || (a_vals.size() != 0 && $urandom_range(0, 1))) begin
                issue(mk_cmd(MODE_LOAD_A, a_vals.pop_front()), gappy);
            end else begin
                issue(mk_cmd(MODE_LOAD_B, b_vals.pop_front()), gappy);
            end
        end
        issue(mk_cmd($urandom_range(0, 1) ? MODE_ISECT : MODE_DIFF, 16'($urandom)), gappy);
    endtask

    task automatic run_noise(bit gappy);
        int n;
        n = $urandom_range(1, 6);
        repeat (n) issue(mk_cmd(2'($urandom), 16'($urandom)), gappy);
    endtask

    initial begin
        int seq_count;
        bit gappy;
        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        n_items = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // runs on empty lists
        issue(mk_cmd(MODE_ISECT, 16'h0000), 1'b0);
        issue(mk_cmd(MODE_DIFF, 16'hffff), 1'b1);
        // value extremes
        issue(mk_cmd(MODE_LOAD_A, 16'h0000), 1'b0);
        issue(mk_cmd(MODE_LOAD_A, 16'hffff), 1'b0);
        issue(mk_cmd(MODE_LOAD_B, 16'hffff), 1'b1);
        issue(mk_cmd(MODE_ISECT, 16'h5a5a), 1'b0);
        // difference with B empty
        issue(mk_cmd(MODE_LOAD_A, 16'd1), 1'b0);
        issue(mk_cmd(MODE_LOAD_A, 16'd2), 1'b0);
        issue(mk_cmd(MODE_DIFF, 16'd0), 1'b1);
        // difference with A empty
        issue(mk_cmd(MODE_LOAD_B, 16'd7), 1'b0);
        issue(mk_cmd(MODE_DIFF, 16'd0), 1'b0);
        // unsorted loads and duplicates
        issue(mk_cmd(MODE_LOAD_A, 16'd5), 1'b0);
        issue(mk_cmd(MODE_LOAD_A, 16'd3), 1'b0);
        issue(mk_cmd(MODE_LOAD_A, 16'd5), 1'b1);
        issue(mk_cmd(MODE_LOAD_B, 16'd5), 1'b0);
        issue(mk_cmd(MODE_LOAD_B, 16'd5), 1'b0);
        issue(mk_cmd(MODE_LOAD_B, 16'd3), 1'b0);
        issue(mk_cmd(MODE_ISECT, 16'd0), 1'b0);
        // difference that removes everything
        issue(mk_cmd(MODE_LOAD_A, 16'd4), 1'b0);
        issue(mk_cmd(MODE_LOAD_A, 16'd9), 1'b0);
        issue(mk_cmd(MODE_LOAD_B, 16'd4), 1'b0);
        issue(mk_cmd(MODE_LOAD_B, 16'd9), 1'b0);
        issue(mk_cmd(MODE_DIFF, 16'd0), 1'b0);
        drain_results();

        seq_count = 0;
        while (n_items < TOTAL_ITEMS) begin
            gappy = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8) run_random_set(gappy);
            else run_noise(gappy);
            seq_count++;
            if (seq_count % 12 == 0) drain_results();
        end

        idle_cycles(1);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
